@@ hdl/hcsc_pkg.sv @@
// Shared types and constants for the hex cell sequence number codec.
// No dependencies.
package hcsc_pkg;

  localparam int unsigned FACE_MAX = 19;

  typedef enum logic [1:0] {
    APT_3   = 2'd0,
    APT_4   = 2'd1,
    APT_7   = 2'd2,
    APT_ONE = 2'd3
  } aperture_t;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_FACE = 2'd1,
    ST_ZERO_SEQ = 2'd2
  } status_t;

  typedef enum logic {
    CFG_RESOLUTION = 1'b0,
    CFG_APERTURE   = 1'b1
  } cfg_index_t;

  // One pipeline stage's item state.
  typedef struct packed {
    logic        op;
    logic [1:0]  status;
    logic [4:0]  face;
    logic [31:0] row;
    logic [31:0] column;
    logic [30:0] i;
    logic [30:0] j;
    logic [62:0] plo;
    logic [31:0] phi;
    logic [63:0] fcpf;
    logic [63:0] seq;
    logic [63:0] dvd;
    logic [63:0] rem;
    logic [4:0]  q1;
    logic        big;
    logic [29:0] q2;
  } stage_t;

endpackage

@@ hdl/hcsc_if.sv @@
// Valid/ready channel interfaces for the codec: item input, result output, config writes.
// No dependencies.
interface hcsc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [4:0]  face;
  logic [31:0] row;
  logic [31:0] column;
  logic [63:0] seqnum_in;
  modport source (output valid, operation, face, row, column, seqnum_in, input ready);
  modport sink (input valid, operation, face, row, column, seqnum_in, output ready);
endinterface

interface hcsc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] seqnum_out;
  logic [4:0]  face_out;
  logic [29:0] row_out;
  logic [29:0] column_out;
  logic [1:0]  status;
  modport source (output valid, seqnum_out, face_out, row_out, column_out, status,
                  input ready);
  modport sink (input valid, seqnum_out, face_out, row_out, column_out, status,
                output ready);
endinterface

interface hcsc_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [4:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/hex_cell_seqnum_codec.sv @@
// Top level of the hex cell sequence number codec: encode/decode pipeline and side sequencer.
// Depends on hcsc_pkg and the channel interfaces in hcsc_if.sv.

// Converts (face, row, column) to a 1-based sequence number or back. One item is
// taken per cycle unless the output stalls or side is being rebuilt. Results pass
// through two 64-stage restoring dividers (sequence number by cells per face, then
// the remainder by side), one quotient bit per stage. Encode work (clamp, two 32-bit
// partial products, face offset, final add) rides in stages 1 to 4. A stall
// on the output freezes the whole pipe; nothing is dropped or repeated. After any
// config write, side and side*side are rebuilt by repeated multiplication by the
// aperture; input ready stays low during that time.
module hex_cell_seqnum_codec (
  input  logic              clk,
  input  logic              rst,
  hcsc_in_if.sink           in_ch,
  hcsc_out_if.source        out_ch,
  hcsc_cfg_if.sink          cfg
);
  import hcsc_pkg::*;

  localparam int NDIV = 64;
  localparam int LAST = 2 * NDIV;

  // ---------------- config and side sequencer ----------------
  logic [4:0]  resolution;
  aperture_t   aperture_code;
  logic [63:0] side, cpf, side_x, cpf_x, side_m1;
  logic        busy;
  logic [4:0]  cnt, count;

  always_comb begin
    case (aperture_code)
      APT_3: begin
        count  = 5'((6'(resolution) + 6'd1) >> 1);
        side_x = (side << 1) + side;
        cpf_x  = (cpf << 3) + cpf;
      end
      APT_4: begin
        count  = resolution;
        side_x = side << 2;
        cpf_x  = cpf << 4;
      end
      APT_7: begin
        count  = resolution;
        side_x = (side << 3) - side;
        cpf_x  = (cpf << 5) + (cpf << 4) + cpf;
      end
      default: begin
        count  = 5'd0;
        side_x = side;
        cpf_x  = cpf;
      end
    endcase
  end

  assign side_m1   = side - 64'd1;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution    <= 5'd0;
      aperture_code <= APT_4;
      side          <= 64'd1;
      cpf           <= 64'd1;
      busy          <= 1'b0;
      cnt           <= 5'd0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_RESOLUTION: resolution <= cfg.data;
        CFG_APERTURE:   aperture_code <= aperture_t'(cfg.data[1:0]);
        default: ;
      endcase
      busy <= 1'b1;
      cnt  <= 5'd0;
      side <= 64'd1;
      cpf  <= 64'd1;
    end else if (busy) begin
      if (cnt < count) begin
        side <= side_x;
        cpf  <= cpf_x;
        cnt  <= cnt + 5'd1;
      end else begin
        busy <= 1'b0;
        // side*side wraps to zero for aperture 4 at high resolution
        if (cpf == 64'd0) cpf <= 64'd1;
      end
    end
  end

  // ---------------- pipeline ----------------
  stage_t st [0:LAST];
  logic   v  [0:LAST];
  logic   adv;
  stage_t s0_next;

  assign adv         = !v[LAST] || out_ch.ready;
  assign in_ch.ready = adv && !busy;

  // stage 0: capture, error status, seqnum - 1
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (adv) v[0] <= in_ch.valid && !busy;
  end

  always_comb begin
    s0_next        = '0;
    s0_next.op     = in_ch.operation;
    s0_next.face   = in_ch.face;
    s0_next.row    = in_ch.row;
    s0_next.column = in_ch.column;
    s0_next.dvd    = in_ch.seqnum_in - 64'd1;
    if (in_ch.operation == OP_ENCODE && 32'(in_ch.face) > FACE_MAX)
      s0_next.status = ST_BAD_FACE;
    else if (in_ch.operation == OP_DECODE && in_ch.seqnum_in == 64'd0)
      s0_next.status = ST_ZERO_SEQ;
    else
      s0_next.status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (adv) st[0] <= s0_next;
  end

  for (genvar k = 1; k <= LAST; k++) begin : g_stage
    stage_t      pr, nx;
    logic [63:0] r_in, d_in, dvs;
    logic [64:0] trial;
    logic        qb;
    logic [5:0]  q6;

    assign pr = st[k-1];

    always_comb begin
      nx = pr;
      // encode steps in the leading stages
      if (k == 1) begin
        if (pr.row[31]) nx.i = '0;
        else if ({32'b0, pr.row} > side_m1) nx.i = side_m1[30:0];
        else nx.i = pr.row[30:0];
        if (pr.column[31]) nx.j = '0;
        else if ({32'b0, pr.column} > side_m1) nx.j = side_m1[30:0];
        else nx.j = pr.column[30:0];
      end
      if (k == 2) nx.plo = 63'({32'b0, pr.i} * {31'b0, side[31:0]});
      if (k == 3) begin
        nx.phi  = 32'({32'b0, pr.i} * {31'b0, side[63:32]});
        nx.seq  = {1'b0, pr.plo} + {33'b0, pr.j} + 64'd1;
        nx.fcpf = cpf * {59'b0, pr.face};
      end
      if (k == 4) nx.seq = pr.fcpf + {pr.phi, 32'b0} + pr.seq;

      // restoring division step
      if (k == NDIV + 1) begin
        r_in = '0;
        d_in = pr.rem;
      end else begin
        r_in = pr.rem;
        d_in = pr.dvd;
      end
      dvs    = (k <= NDIV) ? cpf : side;
      trial  = {r_in, d_in[63]};
      qb     = trial >= {1'b0, dvs};
      nx.rem = qb ? 64'(trial - {1'b0, dvs}) : trial[63:0];
      nx.dvd = {d_in[62:0], 1'b0};
      q6     = {pr.q1, qb};
      if (k <= NDIV) begin
        nx.big = pr.big || (q6 > 6'(FACE_MAX));
        nx.q1  = q6[4:0];
      end else begin
        nx.q2 = {pr.q2[28:0], qb};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) v[k] <= 1'b0;
      else if (adv) v[k] <= v[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) st[k] <= nx;
    end
  end

  // ---------------- result ----------------
  logic ok_enc, ok_dec;
  assign ok_enc = st[LAST].status == ST_OK && st[LAST].op == OP_ENCODE;
  assign ok_dec = st[LAST].status == ST_OK && st[LAST].op == OP_DECODE;

  assign out_ch.valid      = v[LAST];
  assign out_ch.status     = st[LAST].status;
  assign out_ch.seqnum_out = ok_enc ? st[LAST].seq : '0;
  assign out_ch.face_out   = !ok_dec ? '0 : (st[LAST].big ? 5'(FACE_MAX) : st[LAST].q1);
  assign out_ch.row_out    = ok_dec ? st[LAST].q2 : '0;
  assign out_ch.column_out = ok_dec ? st[LAST].rem[29:0] : '0;

  // ---------------- checks ----------------
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ch.ready) else $error("item taken while side is rebuilt");

  a_cpf_nonzero: assert property (@(posedge clk) disable iff (rst)
    !busy |-> cpf != 64'd0) else $error("cells per face is zero");

  a_face_err_enc: assert property (@(posedge clk) disable iff (rst)
    (v[LAST] && st[LAST].status == ST_BAD_FACE) |-> st[LAST].op == OP_ENCODE)
    else $error("face error on a decode");

endmodule

@@ tb/sv/tb_hex_cell_seqnum_codec.sv @@
`timescale 1ns / 1ps
// Self-checking bench for hex_cell_seqnum_codec: random and directed encode/decode items
// across many resolution/aperture settings. Depends on hcsc_pkg and the hcsc_if interfaces.
module tb_hex_cell_seqnum_codec;
  import hcsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 160;   // pipe is 129 deep plus config rebuild

  typedef struct {
    op_t                operation;
    logic [4:0]         face;
    logic signed [31:0] row;
    logic signed [31:0] column;
    logic [63:0]        seqnum_in;
  } cell_item_t;

  typedef struct {
    logic [63:0] seqnum;
    logic [4:0]  face;
    logic [29:0] row;
    logic [29:0] column;
    status_t     status;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hcsc_in_if  in_ch ();
  hcsc_out_if out_ch ();
  hcsc_cfg_if cfg ();

  hex_cell_seqnum_codec i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // Bench copy of the two config registers, updated on each cfg transfer.
  logic [4:0] cur_res = 5'd0;
  aperture_t  cur_apt = APT_4;

  cell_item_t   pending_items[$];
  cell_result_t expected_results[$];

  int  errors = 0;
  int  n_encode = 0, n_decode = 0, n_status_err = 0, n_phases = 0;
  int  idle_cycles = 0;
  bit  in_fired = 1'b0;
  int  burst_left = 1, gap_left = 0;
  int  cyc = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Face side length; wraps modulo 2^64 like the hardware multiplier.
  function automatic longint unsigned face_side(logic [4:0] res, aperture_t apt);
    longint unsigned m;
    longint unsigned base;
    int count;
    m = 1;
    case (apt)
      APT_3:   begin base = 3; count = (int'(res) + 1) / 2; end
      APT_4:   begin base = 4; count = res; end
      APT_7:   begin base = 7; count = res; end
      default: begin base = 1; count = 0; end
    endcase
    for (int k = 0; k < count; k++) m = m * base;
    if (m == 0) m = 1;
    return m;
  endfunction

  // Negative coordinates go to 0, anything past the face edge to side-1.
  function automatic longint unsigned clamp_coord(logic signed [31:0] v,
                                                  longint unsigned side);
    longint unsigned u;
    u = {32'b0, v};
    if (v < 0) return 0;
    if (u > side - 1) return side - 1;
    return u;
  endfunction

  function automatic cell_result_t convert_cell(cell_item_t it, logic [4:0] res,
                                                aperture_t apt);
    cell_result_t    r;
    longint unsigned side, cpf, s, q, idx, ci, cj;
    side = face_side(res, apt);
    cpf  = side * side;
    if (cpf == 0) cpf = 1;
    r = '{seqnum: 64'd0, face: 5'd0, row: 30'd0, column: 30'd0, status: ST_OK};
    if (it.operation == OP_ENCODE) begin
      if (it.face > FACE_MAX) begin
        r.status = ST_BAD_FACE;
      end else begin
        ci = clamp_coord(it.row, side);
        cj = clamp_coord(it.column, side);
        r.seqnum = longint'(it.face) * cpf + ci * side + cj + 1;
      end
    end else begin
      if (it.seqnum_in == 64'd0) begin
        r.status = ST_ZERO_SEQ;
      end else begin
        s   = it.seqnum_in - 1;
        q   = s / cpf;
        idx = s % cpf;
        r.face   = (q > FACE_MAX) ? 5'(FACE_MAX) : 5'(q);
        r.row    = 30'(idx / side);
        r.column = 30'(idx % side);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: bursts with random gaps; holds the item until transfer.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_fired)) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (pending_items.size() > 0) begin
        in_ch.valid     <= 1'b1;
        in_ch.operation <= pending_items[0].operation;
        in_ch.face      <= pending_items[0].face;
        in_ch.row       <= pending_items[0].row;
        in_ch.column    <= pending_items[0].column;
        in_ch.seqnum_in <= pending_items[0].seqnum_in;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: stall-free windows, random stalls, and a fixed
  // periodic stall, switching with bits 9:8 of the cycle counter.
  always @(negedge clk) begin
    cyc++;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (cyc[9:8])
        2'd0:    out_ch.ready <= 1'b1;
        2'd1:    out_ch.ready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_ch.ready <= (cyc % 7 != 3) && (cyc % 11 != 5);
        default: out_ch.ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on input transfer, checks on output transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cell_item_t   it;
    cell_result_t exp_r;
    bit           any_transfer;
    any_transfer = 1'b0;
    in_fired <= !rst && in_ch.valid && in_ch.ready;
    if (!rst) begin
      if (cfg.valid && cfg.ready) begin
        any_transfer = 1'b1;
        if (cfg_index_t'(cfg.index) == CFG_RESOLUTION) cur_res = cfg.data;
        else cur_apt = aperture_t'(cfg.data[1:0]);
      end
      if (in_ch.valid && in_ch.ready) begin
        any_transfer = 1'b1;
        it = pending_items.pop_front();
        exp_r = convert_cell(it, cur_res, cur_apt);
        if (exp_r.status != ST_OK) n_status_err++;
        if (it.operation == OP_ENCODE) n_encode++;
        else n_decode++;
        expected_results.push_back(exp_r);
      end
      if (out_ch.valid && out_ch.ready) begin
        any_transfer = 1'b1;
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: seqnum=%h face=%0d row=%0d col=%0d st=%0d",
                   $time, out_ch.seqnum_out, out_ch.face_out, out_ch.row_out,
                   out_ch.column_out, out_ch.status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.seqnum_out !== exp_r.seqnum) begin
            $display("%0t: seqnum_out exp %h got %h", $time, exp_r.seqnum, out_ch.seqnum_out);
            errors++;
          end
          if (out_ch.face_out !== exp_r.face) begin
            $display("%0t: face_out exp %0d got %0d", $time, exp_r.face, out_ch.face_out);
            errors++;
          end
          if (out_ch.row_out !== exp_r.row) begin
            $display("%0t: row_out exp %0d got %0d", $time, exp_r.row, out_ch.row_out);
            errors++;
          end
          if (out_ch.column_out !== exp_r.column) begin
            $display("%0t: column_out exp %0d got %0d", $time, exp_r.column,
                     out_ch.column_out);
            errors++;
          end
          if (out_ch.status !== exp_r.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.status, out_ch.status);
            errors++;
          end
        end
      end
    end
    // Watchdog: too long without any transfer means the block is hung.
    if (any_transfer) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_index_t idx, logic [4:0] value);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic add_encode(logic [4:0] f, logic [31:0] r, logic [31:0] c);
    pending_items.push_back('{OP_ENCODE, f, r, c, {$urandom, $urandom}});
  endtask

  task automatic add_decode(logic [63:0] s);
    pending_items.push_back('{OP_DECODE, 5'($urandom), 32'($urandom), 32'($urandom), s});
  endtask

  // Random coordinate: mostly inside the face, some past the edge or negative.
  function automatic logic [31:0] pick_coord(longint unsigned side);
    case ($urandom_range(0, 9))
      0:       return $urandom | 32'h8000_0000;
      1:       return $urandom;
      2:       return (side > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(side - 1);
      3:       return 32'(side > 32'h7FFF_FFFF ? 32'h7FFF_FFFF : side) + $urandom_range(0, 3);
      default: return (side > 32'h7FFF_FFFF) ? {1'b0, 31'($urandom)}
                                              : 32'({$urandom, $urandom} % side);
    endcase
  endfunction

  function automatic logic [63:0] pick_seqnum(longint unsigned side);
    longint unsigned cpf, span;
    cpf = side * side;
    if (cpf == 0) cpf = 1;
    span = cpf * 20;
    case ($urandom_range(0, 9))
      0:       return {$urandom, $urandom};
      1:       return $urandom_range(0, 2);
      2:       return cpf * $urandom_range(1, 24) + $urandom_range(0, 1);
      default: return (span / 20 == cpf && span != 0) ? ({$urandom, $urandom} % span) + 1
                                                      : {$urandom, $urandom};
    endcase
  endfunction

  task automatic run_phase(logic [4:0] res, aperture_t apt, int n_items);
    longint unsigned side;
    side = face_side(res, apt);
    write_reg(CFG_RESOLUTION, res);
    write_reg(CFG_APERTURE, 5'(apt));
    n_phases++;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 1) == 0)
        add_encode(($urandom_range(0, 7) == 0) ? 5'($urandom_range(20, 31))
                                               : 5'($urandom_range(0, 19)),
                   pick_coord(side), pick_coord(side));
      else
        add_decode(pick_seqnum(side));
    end
    // Config may only change with the pipe empty.
    do @(posedge clk); while (pending_items.size() != 0 || expected_results.size() != 0);
  endtask

  initial begin
    in_ch.valid = 1'b0;  in_ch.operation = OP_ENCODE;  in_ch.face = '0;
    in_ch.row = '0;      in_ch.column = '0;            in_ch.seqnum_in = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;    cfg.index = CFG_RESOLUTION;    cfg.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b1;
    @(negedge clk);
    rst = 1'b0;

    // Directed items at aperture 4, resolution 2 (side 16, 256 cells per face).
    run_phase(5'd2, APT_4, 0);
    add_encode(5'd0, 32'd0, 32'd0);
    add_encode(5'd19, 32'd3, 32'd3);
    add_encode(5'd20, 32'd1, 32'd1);                       // first bad face
    add_encode(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);       // bad face, all ones
    add_encode(5'd5, 32'h8000_0000, 32'h7FFF_FFFF);        // clamp both ways
    add_encode(5'd7, 32'hFFFF_FFFF, 32'd4);                // -1 row, column inside the face
    add_encode(5'd10, 32'd2, 32'h8000_0000);
    add_decode(64'd0);                                     // zero seqnum
    add_decode(64'd1);
    add_decode(64'd16);
    add_decode(64'd17);
    add_decode(64'd320);                                   // face 1, row 3, column 15
    add_decode(64'd321);                                   // face 1, row 4, column 0
    add_decode(64'hFFFF_FFFF_FFFF_FFFF);
    add_decode(64'h8000_0000_0000_0000);
    add_decode(64'h5555_5555_5555_5555);
    add_decode(64'hAAAA_AAAA_AAAA_AAAA);
    do @(posedge clk); while (pending_items.size() != 0 || expected_results.size() != 0);

    // Sweep settings, extremes included; resolution zero, unused aperture code,
    // sides whose square wraps to zero.
    run_phase(5'd0, APT_4, 130);
    run_phase(5'd0, APT_3, 130);
    run_phase(5'd1, APT_3, 140);
    run_phase(5'd5, APT_7, 140);
    run_phase(5'd3, APT_ONE, 120);
    run_phase(5'd16, APT_4, 140);
    run_phase(5'd30, APT_4, 140);
    run_phase(5'd31, APT_4, 140);
    run_phase(5'd30, APT_7, 140);
    run_phase(5'd31, APT_7, 140);
    run_phase(5'd31, APT_3, 140);
    run_phase(5'd4, APT_3, 140);
    run_phase(5'd10, APT_ONE, 100);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d config settings: %0d encodes, %0d decodes, %0d error-status items.",
             n_phases, n_encode, n_decode, n_status_err);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, expected_results.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/hcsc_pkg.sv
hdl/hcsc_if.sv
hdl/hex_cell_seqnum_codec.sv
tb/sv/tb_hex_cell_seqnum_codec.sv
